@@ rtl/dts_pkg.sv @@
package dts_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_ESCAPE = 3'd4,
    MODE_COLON  = 3'd5,
    MODE_HALTED = 3'd6
  } mode_e;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] CLS_KEYWORD = 3'd0;
  localparam logic [2:0] CLS_IDENT   = 3'd1;
  localparam logic [2:0] CLS_STRING  = 3'd2;
  localparam logic [2:0] CLS_INTEGER = 3'd3;
  localparam logic [2:0] CLS_OPER    = 3'd4;
  localparam logic [2:0] CLS_ASSIGN  = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_QUOTE    = 2'd1;
  localparam logic [1:0] ERR_UNEXPECT = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_UNDER     = 8'h5F;

  localparam int KW_NUM = 7;
  localparam logic [63:0] KW_RESET [KW_NUM] = '{
    64'd1802723700, 64'd7239026, 64'd521610294885, 64'd26217,
    64'd495740084582, 64'd1684956531, 64'd28532
  };

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value_char;
    logic [2:0] token_class;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic [1:0]                 count;
    logic [15:0]                line;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

endpackage

@@ rtl/dts_in_if.sv @@
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink (input valid, input req_type, input char_code, output ready);
endinterface

@@ rtl/dts_out_if.sv @@
interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  value_char;
  logic [2:0]  token_class;
  logic [1:0]  error_code;
  logic [15:0] line_number;
  logic        last;

  modport source (output valid, output result_kind, output value_char, output token_class,
                  output error_code, output line_number, output last, input ready);
  modport sink (input valid, input result_kind, input value_char, input token_class,
                input error_code, input line_number, input last, output ready);
endinterface

@@ rtl/dts_front.sv @@
module dts_front #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LINE_BITS     = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  dts_in_if.sink         chars,
  output dts_pkg::push_t push,
  input  logic           q_full
);
  import dts_pkg::*;

  localparam int LEN_W = $clog2(KEYWORD_CHARS + 2);

  mode_e                         mode, mode_next;
  logic [KEYWORD_CHARS-1:0][7:0] ident_buf, ident_buf_next;
  logic [LEN_W-1:0]              ident_len, ident_len_next;
  logic [LINE_BITS-1:0]          line_cnt, line_cnt_next;
  logic [63:0]                   kw [KW_NUM];

  logic        accept;
  logic        is_end;
  logic [7:0]  c;
  logic        kw_hit;
  logic [31:0] line_wide;
  logic [15:0] line_sat;
  result_t [MAX_RES-1:0] res;
  logic [1:0]  n;

  function automatic logic is_space(input logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_oper(input logic [7:0] ch);
    return ch == 8'h7B || ch == 8'h7D || ch == 8'h28 || ch == 8'h29 || ch == 8'h2C ||
           ch == CH_EQUAL || ch == 8'h2B || ch == 8'h2D || ch == 8'h2A || ch == 8'h2F;
  endfunction

  function automatic mode_e idle_mode(input logic [7:0] ch);
    if (is_space(ch)) return MODE_IDLE;
    else if (is_alpha(ch) || ch == CH_UNDER) return MODE_IDENT;
    else if (is_digit(ch)) return MODE_NUMBER;
    else if (ch == CH_QUOTE) return MODE_STRING;
    else if (ch == CH_COLON) return MODE_COLON;
    else if (is_oper(ch)) return MODE_IDLE;
    else return MODE_HALTED;
  endfunction

  function automatic result_t mk(input logic [1:0] kind, input logic [7:0] ch,
                                 input logic [2:0] cls, input logic [1:0] err);
    result_t r;
    r.kind        = kind;
    r.value_char  = ch;
    r.token_class = cls;
    r.error_code  = err;
    return r;
  endfunction

  assign chars.ready = !q_full;
  assign accept      = chars.valid && chars.ready;
  assign is_end      = chars.req_type == REQ_END;
  assign c           = chars.char_code;

  always_comb begin
    kw_hit = 1'b0;
    for (int i = 0; i < KW_NUM; i++) begin
      if (kw[i] != 64'd0 && kw[i] == 64'(ident_buf)) kw_hit = 1'b1;
    end
    if (ident_len > LEN_W'(KEYWORD_CHARS)) kw_hit = 1'b0;
  end

  assign line_wide = 32'(line_cnt);
  assign line_sat  = (line_wide > 32'hFFFF) ? 16'hFFFF : line_wide[15:0];

  // next scan mode
  always_comb begin
    if (is_end) begin
      mode_next = MODE_IDLE;
    end else begin
      case (mode)
        MODE_HALTED: mode_next = MODE_HALTED;
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) mode_next = MODE_IDENT;
          else mode_next = idle_mode(c);
        end
        MODE_NUMBER: begin
          if (is_digit(c)) mode_next = MODE_NUMBER;
          else mode_next = idle_mode(c);
        end
        MODE_COLON: begin
          if (c == CH_EQUAL) mode_next = MODE_IDLE;
          else mode_next = idle_mode(c);
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) mode_next = MODE_IDLE;
          else if (c == CH_BACKSLASH) mode_next = MODE_ESCAPE;
          else if (c == CH_NEWLINE) mode_next = MODE_HALTED;
          else mode_next = MODE_STRING;
        end
        MODE_ESCAPE: begin
          if (c == CH_NEWLINE) mode_next = MODE_HALTED;
          else mode_next = MODE_STRING;
        end
        default: mode_next = idle_mode(c);
      endcase
    end
  end

  // results, token buffer and line counter
  always_comb begin
    logic             do_idle;
    logic [LEN_W-1:0] base_len;
    res            = '0;
    n              = 2'd0;
    do_idle        = 1'b0;
    base_len       = '0;
    ident_buf_next = ident_buf;
    ident_len_next = ident_len;
    line_cnt_next  = line_cnt;
    if (is_end) begin
      case (mode)
        MODE_IDENT: begin
          res[n] = mk(KIND_END, 8'd0, kw_hit ? CLS_KEYWORD : CLS_IDENT, ERR_NONE);
          n = n + 2'd1;
        end
        MODE_NUMBER: begin
          res[n] = mk(KIND_END, 8'd0, CLS_INTEGER, ERR_NONE);
          n = n + 2'd1;
        end
        MODE_COLON: begin
          res[n] = mk(KIND_END, 8'd0, CLS_OPER, ERR_NONE);
          n = n + 2'd1;
        end
        MODE_STRING, MODE_ESCAPE: begin
          res[n] = mk(KIND_ERROR, 8'd0, 3'd0, ERR_QUOTE);
          n = n + 2'd1;
        end
        default: ;
      endcase
      ident_buf_next = '0;
      ident_len_next = '0;
      line_cnt_next  = LINE_BITS'(1);
    end else begin
      case (mode)
        MODE_HALTED: ;
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (ident_len == LEN_W'(i)) ident_buf_next[i] = c;
            end
            if (ident_len <= LEN_W'(KEYWORD_CHARS)) ident_len_next = ident_len + 1'b1;
            res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
            n = n + 2'd1;
          end else begin
            res[n] = mk(KIND_END, 8'd0, kw_hit ? CLS_KEYWORD : CLS_IDENT, ERR_NONE);
            n = n + 2'd1;
            ident_buf_next = '0;
            ident_len_next = '0;
            do_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
            n = n + 2'd1;
          end else begin
            res[n] = mk(KIND_END, 8'd0, CLS_INTEGER, ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_COLON: begin
          if (c == CH_EQUAL) begin
            res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
            n = n + 2'd1;
            res[n] = mk(KIND_END, 8'd0, CLS_ASSIGN, ERR_NONE);
            n = n + 2'd1;
          end else begin
            res[n] = mk(KIND_END, 8'd0, CLS_OPER, ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            res[n] = mk(KIND_END, 8'd0, CLS_STRING, ERR_NONE);
            n = n + 2'd1;
          end else if (c == CH_NEWLINE) begin
            res[n] = mk(KIND_ERROR, 8'd0, 3'd0, ERR_QUOTE);
            n = n + 2'd1;
          end else if (c != CH_BACKSLASH) begin
            res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
            n = n + 2'd1;
          end
        end
        MODE_ESCAPE: begin
          if (c == CH_NEWLINE) res[n] = mk(KIND_ERROR, 8'd0, 3'd0, ERR_QUOTE);
          else res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
          n = n + 2'd1;
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        if (is_space(c)) begin
          if (c == CH_NEWLINE && line_cnt != '1) line_cnt_next = line_cnt + 1'b1;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          ident_buf_next = '0;
          for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (base_len == LEN_W'(i)) ident_buf_next[i] = c;
          end
          ident_len_next = base_len + 1'b1;
          res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
          n = n + 2'd1;
        end else if (is_digit(c) || c == CH_COLON) begin
          res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
          n = n + 2'd1;
        end else if (is_oper(c)) begin
          res[n] = mk(KIND_VALUE, c, 3'd0, ERR_NONE);
          n = n + 2'd1;
          res[n] = mk(KIND_END, 8'd0, CLS_OPER, ERR_NONE);
          n = n + 2'd1;
        end else if (c != CH_QUOTE) begin
          res[n] = mk(KIND_ERROR, 8'd0, 3'd0, ERR_UNEXPECT);
          n = n + 2'd1;
        end
      end
    end
  end

  always_comb begin
    push.valid        = accept && n != 2'd0;
    push.bundle.count = n;
    push.bundle.line  = line_sat;
    push.bundle.res   = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      ident_buf <= '0;
      ident_len <= '0;
      line_cnt  <= LINE_BITS'(1);
      for (int i = 0; i < KW_NUM; i++) kw[i] <= KW_RESET[i];
    end else begin
      if (accept) begin
        mode      <= mode_next;
        ident_buf <= ident_buf_next;
        ident_len <= ident_len_next;
        line_cnt  <= line_cnt_next;
      end
      if (cfg_we && cfg_index < 3'(KW_NUM)) kw[cfg_index] <= cfg_data;
    end
  end

endmodule

@@ rtl/dts_queue.sv @@
module dts_queue (
  input  logic             clk,
  input  logic             rst,
  input  dts_pkg::push_t   push,
  output logic             full,
  input  logic             pop,
  output dts_pkg::bundle_t head,
  output logic             empty
);
  import dts_pkg::*;

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push.valid, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ rtl/dts_back.sv @@
module dts_back (
  input  logic             clk,
  input  logic             rst,
  input  dts_pkg::bundle_t head,
  input  logic             q_empty,
  output logic             pop,
  dts_out_if.source        tokens
);
  import dts_pkg::*;

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       is_last;
  logic       advance;
  result_t    sel;

  assign is_last = idx == cur.count - 2'd1;
  assign advance = !cur_valid || (tokens.ready && is_last);
  assign pop     = advance && !q_empty;
  assign sel     = cur.res[idx];

  assign tokens.valid       = cur_valid;
  assign tokens.result_kind = sel.kind;
  assign tokens.value_char  = sel.value_char;
  assign tokens.token_class = sel.token_class;
  assign tokens.error_code  = sel.error_code;
  assign tokens.line_number = cur.line;
  assign tokens.last        = is_last;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (advance) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (tokens.ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

@@ rtl/dsl_token_scanner_core.sv @@
// results are registered in the queue, then in the sequencer's register
// throughput: one character per cycle while tokens.ready holds and each
//   gives at most one result; a character with k results takes k transfers,
//   a 2-entry queue between scanner and sequencer absorbs the difference
// reset: scan mode idle, line 1, keyword registers to their defaults, queue empty
module dsl_token_scanner_core #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LINE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  dts_in_if.sink      chars,
  dts_out_if.source   tokens
);
  import dts_pkg::*;

  push_t   push;
  bundle_t head;
  logic    q_full;
  logic    q_empty;
  logic    pop;

  dts_front #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .LINE_BITS     (LINE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (chars),
    .push      (push),
    .q_full    (q_full)
  );

  dts_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head),
    .empty (q_empty)
  );

  dts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .tokens  (tokens)
  );

endmodule
